>>> rtl/core/usc_pkg.sv
// Package: types and constants for the unit string character scanner.
`timescale 1ns / 1ps

package usc_pkg;

  localparam int MAX_DEPTH_DEF = 255;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam logic [7:0] UTF_LEAD_C2 = 8'hC2;
  localparam logic [7:0] UTF_LEAD_CE = 8'hCE;
  localparam logic [7:0] UTF_LEAD_CF = 8'hCF;
  localparam logic [7:0] UTF_LEAD_E2 = 8'hE2;
  localparam logic [7:0] UTF_DEGREE  = 8'hB0;
  localparam logic [7:0] UTF_CE_LO   = 8'h91;
  localparam logic [7:0] UTF_CONT_HI = 8'hBF;
  localparam logic [7:0] UTF_CONT_LO = 8'h80;
  localparam logic [7:0] UTF_E2_MID  = 8'h84;
  localparam logic [7:0] UTF_LL_LO   = 8'h83;
  localparam logic [7:0] UTF_LL_HI   = 8'hAB;

  typedef enum logic [2:0] {
    PH_SYMBOL    = 3'd0,
    PH_OPERATOR  = 3'd1,
    PH_EXP_START = 3'd2,
    PH_EXP_SIGN  = 3'd3,
    PH_EXPONENT  = 3'd4,
    PH_ERROR     = 3'd5,
    PH_END       = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    UTF_NONE  = 3'd0,
    UTF_C2    = 3'd1,
    UTF_CE    = 3'd2,
    UTF_CF    = 3'd3,
    UTF_E2    = 3'd4,
    UTF_E2_84 = 3'd5
  } utf_lead_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       new_string;
  } in_item_t;

  typedef struct packed {
    logic       more_expected;
    logic [2:0] scan_state;
    logic [7:0] bracket_level;
  } out_item_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] open_brackets;
    logic       exp_bracket_open;
    utf_lead_t  utf_pending;
  } scan_st_t;

  localparam scan_st_t SCAN_START = '{
    phase:            PH_OPERATOR,
    open_brackets:    8'd0,
    exp_bracket_open: 1'b0,
    utf_pending:      UTF_NONE
  };

endpackage

>>> rtl/core/usc_step.sv
// Next-state logic of the scan grammar for one byte.
`timescale 1ns / 1ps

module usc_step import usc_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  scan_st_t  cur_st,
  input  in_item_t  item,
  output scan_st_t  nxt_st
);

  localparam logic [7:0] DEPTH_BOUND = (MAX_DEPTH < 255) ? 8'(MAX_DEPTH) : 8'd255;

  scan_st_t   base;
  logic [7:0] b;
  logic       is_letter;
  logic       is_digit;
  logic       is_op;
  logic       sym_ok;
  utf_lead_t  sym_pend;
  phase_t     ph;
  scan_st_t   st;

  assign b    = item.char_byte;
  assign base = item.new_string ? SCAN_START : cur_st;

  assign is_letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  assign is_digit  = (b >= 8'h30 && b <= 8'h39);
  assign is_op     = (b == CH_STAR) || (b == CH_SLASH) || (b == CH_UNDER);

  // Symbol byte test and the lead it leaves behind when taken
  always_comb begin
    sym_ok   = 1'b0;
    sym_pend = base.utf_pending;
    unique case (base.utf_pending)
      UTF_NONE: begin
        if (is_letter) begin
          sym_ok = 1'b1;
        end else if (b == UTF_LEAD_C2) begin
          sym_ok = 1'b1; sym_pend = UTF_C2;
        end else if (b == UTF_LEAD_CE) begin
          sym_ok = 1'b1; sym_pend = UTF_CE;
        end else if (b == UTF_LEAD_CF) begin
          sym_ok = 1'b1; sym_pend = UTF_CF;
        end else if (b == UTF_LEAD_E2) begin
          sym_ok = 1'b1; sym_pend = UTF_E2;
        end
      end
      UTF_C2: begin
        if (b == UTF_DEGREE) begin
          sym_ok = 1'b1; sym_pend = UTF_NONE;
        end
      end
      UTF_CE: begin
        if (b >= UTF_CE_LO && b <= UTF_CONT_HI) begin
          sym_ok = 1'b1; sym_pend = UTF_NONE;
        end
      end
      UTF_CF: begin
        if (b >= UTF_CONT_LO && b <= UTF_CONT_HI) begin
          sym_ok = 1'b1; sym_pend = UTF_NONE;
        end
      end
      UTF_E2: begin
        if (b == UTF_E2_MID) begin
          sym_ok = 1'b1; sym_pend = UTF_E2_84;
        end
      end
      UTF_E2_84: begin
        if (b >= UTF_LL_LO && b <= UTF_LL_HI) begin
          sym_ok = 1'b1; sym_pend = UTF_NONE;
        end
      end
      default: begin
        sym_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    st = base;
    ph = base.phase;
    unique case (base.phase)
      PH_SYMBOL: begin
        priority if (sym_ok) begin
          ph = PH_SYMBOL; st.utf_pending = sym_pend;
        end else if (is_op) begin
          ph = PH_OPERATOR;
        end else if (b == CH_RPAREN) begin
          if (base.open_brackets == 8'd0) begin
            ph = PH_ERROR;
          end else begin
            st.open_brackets = base.open_brackets - 8'd1;
            ph = PH_SYMBOL;
          end
        end else if (b == CH_CARET) begin
          ph = PH_EXP_START;
        end else begin
          ph = PH_END;
        end
      end
      PH_OPERATOR: begin
        priority if (sym_ok) begin
          ph = PH_SYMBOL; st.utf_pending = sym_pend;
        end else if (b == CH_LPAREN) begin
          if (base.open_brackets >= DEPTH_BOUND) begin
            ph = PH_ERROR;
          end else begin
            st.open_brackets = base.open_brackets + 8'd1;
          end
        end else begin
          ph = PH_ERROR;
        end
      end
      PH_EXP_START: begin
        priority if (b == CH_MINUS || b == CH_PLUS) begin
          ph = PH_EXP_SIGN;
        end else if (b == CH_LPAREN) begin
          if (base.exp_bracket_open) begin
            ph = PH_ERROR;
          end else begin
            st.exp_bracket_open = 1'b1;
            ph = PH_EXP_START;
          end
        end else if (is_digit) begin
          ph = PH_EXPONENT;
        end else begin
          ph = PH_ERROR;
        end
      end
      PH_EXP_SIGN: begin
        ph = is_digit ? PH_EXPONENT : PH_ERROR;
      end
      PH_EXPONENT: begin
        priority if (is_digit) begin
          ph = PH_EXPONENT;
        end else if (is_op) begin
          ph = PH_OPERATOR;
        end else if (b == CH_RPAREN) begin
          priority if (base.exp_bracket_open) begin
            st.exp_bracket_open = 1'b0;
            ph = PH_SYMBOL;
          end else if (base.open_brackets != 8'd0) begin
            st.open_brackets = base.open_brackets - 8'd1;
            ph = PH_SYMBOL;
          end else begin
            ph = PH_ERROR;
          end
        end else begin
          ph = PH_END;
        end
      end
      PH_ERROR: begin
        ph = PH_ERROR;
      end
      default: begin
        ph = PH_END;
      end
    endcase

    // Ending with anything still open is an error
    if (ph == PH_END && (st.open_brackets != 8'd0 || st.exp_bracket_open ||
                         st.utf_pending != UTF_NONE)) begin
      ph = PH_ERROR;
    end
    st.phase = ph;
    nxt_st   = st;
  end

endmodule

>>> rtl/core/unit_string_char_scanner.sv
// Top level: unit string byte scanner with input and result registers.
// The input register holds the accepted item; the result register then takes its scan result.
// One item per cycle while out_stall is low; the scan registers update once per byte.
// A stalled result register still lets one further item enter the input register.
// Reset (rst_n low, synchronous): both stages empty, scan in operator phase,
// depth 0, no exponent bracket, no pending UTF-8 lead.
`timescale 1ns / 1ps

module unit_string_char_scanner import usc_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  scan_st_t  st_r;
  scan_st_t  st_nxt;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic      out_free;
  logic      s1_move;
  logic      in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  usc_step #(.MAX_DEPTH(MAX_DEPTH)) u_step (
    .cur_st (st_r),
    .item   (s1_item_r),
    .nxt_st (st_nxt)
  );

  assign out_item_nxt.more_expected = (st_nxt.phase != PH_ERROR) && (st_nxt.phase != PH_END);
  assign out_item_nxt.scan_state    = st_nxt.phase;
  assign out_item_nxt.bracket_level = st_nxt.open_brackets;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= SCAN_START;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (s1_move) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> rtl/core/usc_checker.sv
// Port-level checker for the unit string scanner, bound to the top level.
`timescale 1ns / 1ps

module usc_checker import usc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  // Hold a stalled input item
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input item changed");

  // Input side only backs up behind a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // End is only reported with every bracket closed
  a_end_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.scan_state == PH_END |->
      out_item.bracket_level == 8'd0 && !out_item.more_expected)
    else $error("end state with open bracket");

endmodule

bind unit_string_char_scanner usc_checker u_usc_checker (.*);
